@@ rtl/brf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte ring FIFO package
// Operation and status codes shared by the byte ring FIFO and its users.
// ----------------------------------------------------------------------------
package brf_pkg;

	typedef logic [2:0] op_t;
	typedef logic [1:0] status_t;

	localparam op_t OP_WRITE = 3'd0;
	localparam op_t OP_READ  = 3'd1;
	localparam op_t OP_PEEK  = 3'd2;
	localparam op_t OP_FIND  = 3'd3;
	localparam op_t OP_CLEAR = 3'd4;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_FULL     = 2'd1;
	localparam status_t ST_EMPTY    = 2'd2;
	localparam status_t ST_NOTFOUND = 2'd3;

	// Capacity register value after reset.
	localparam logic [10:0] CAPACITY_RESET = 11'd1024;

endpackage
`default_nettype wire

@@ rtl/byte_ring_fifo_peek_find.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte ring FIFO with read, peek, find and clear
// A circular byte store in one synchronous RAM, sized at run time by the
// capacity register, walked by a small sequencer for bursts and searches.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on the input channel (in_valid / in_stall), one beat per
// command, carrying operation, data, count and offset. Results leave on the
// output channel (out_valid / out_stall); last marks the final result beat of
// a command. Write, find, clear and every refused command give one beat;
// read and peek give one beat per byte returned.
// The block works on one command at a time. A write, clear or unused code
// passes the accept state S_IDLE and then S_DECIDE, which executes it and
// loads the output register. A read or peek walks each byte through
// S_RD_ADDR, which addresses the RAM, and S_RD_DATA, which hands over its
// registered read data. A find walks the store entry by entry through
// S_FD_ADDR and S_FD_CMP, stopping at the first match or, when nothing
// matches, after the last stored byte.
// The output register lets a new command be accepted while the previous
// result still waits; a stalled receiver holds the sequencer only when it
// has a new beat to hand over. Reset empties the FIFO and sets the capacity
// to 1024 slots; writing the capacity register also empties the FIFO.
// Capacity writes are taken whenever the sequencer is idle.
// ----------------------------------------------------------------------------
module byte_ring_fifo_peek_find #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	// Capacity register write channel.
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire  [10:0]       capacity,
	// Command channel.
	input  wire               in_valid,
	output logic              in_stall,
	input  wire brf_pkg::op_t operation,
	input  wire  [7:0]        data,
	input  wire  [6:0]        count,
	input  wire  [9:0]        offset,
	// Result channel.
	output logic              out_valid,
	input  wire               out_stall,
	output brf_pkg::status_t  status,
	output logic [7:0]        byte_out,
	output logic [9:0]        position,
	output logic [10:0]       fill_level,
	output logic              last
);
	import brf_pkg::*;

	// Index width for the RAM, count width able to hold DEPTH itself, and a
	// working width that holds an index plus an offset without overflow.
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > 10) ? CW : 10) + 1;
	localparam int BW = $clog2(MAX_BURST + 1);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_DECIDE  = 6'b000010,
		S_RD_ADDR = 6'b000100,
		S_RD_DATA = 6'b001000,
		S_FD_ADDR = 6'b010000,
		S_FD_CMP  = 6'b100000
	} state_t;

	// Effective slot count: zero acts as one, anything above DEPTH as DEPTH.
	function automatic logic [CW-1:0] clamp_cap(input logic [10:0] v);
		logic [CW-1:0] r;
		if (v == 11'd0) begin
			r = CW'(1);
		end else if (int'(v) > DEPTH) begin
			r = CW'(DEPTH);
		end else begin
			r = CW'(v);
		end
		return r;
	endfunction

	// Step an index by one, wrapping at the effective capacity.
	function automatic logic [AW-1:0] step_idx(input logic [AW-1:0] idx,
			input logic [CW-1:0] cap);
		logic [AW-1:0] r;
		if ((XW'(idx) + XW'(1)) == XW'(cap)) begin
			r = '0;
		end else begin
			r = AW'(idx + 1'b1);
		end
		return r;
	endfunction

	state_t           state_q;
	op_t              op_q;
	logic [7:0]       data_q;
	logic [6:0]       cnt_q;
	logic [9:0]       off_q;
	logic [CW-1:0]    cap_q;
	logic [AW-1:0]    wr_idx_q;
	logic [AW-1:0]    rd_idx_q;
	logic [CW-1:0]    fill_q;
	logic [AW-1:0]    ptr_q;
	logic [BW-1:0]    left_q;
	logic [CW-1:0]    fi_q;

	logic             out_valid_q;
	status_t          status_q;
	logic [7:0]       byte_out_q;
	logic [9:0]       position_q;
	logic [10:0]      fill_level_q;
	logic             last_q;

	logic [7:0]       byte_store_q [DEPTH];
	logic [7:0]       rdata_q;

	logic             out_free;
	logic             full;
	logic [XW-1:0]    rd_n;
	logic             pk_empty;
	logic [XW-1:0]    pk_avail;
	logic [XW-1:0]    pk_n;
	logic [XW-1:0]    pk_sum;
	logic [AW-1:0]    pk_ptr;
	logic [AW-1:0]    ptr_inc;
	logic             fd_hit;
	logic             fd_end;
	logic             mem_we;
	logic             mem_re;

	logic             emit_req;
	status_t          beat_status;
	logic [7:0]       beat_byte;
	logic [9:0]       beat_pos;
	logic [10:0]      beat_fill;
	logic             beat_last;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign byte_out   = byte_out_q;
	assign position   = position_q;
	assign fill_level = fill_level_q;
	assign last       = last_q;

	// Command arithmetic, all against the effective capacity.
	always_comb begin
		full     = XW'(fill_q) >= XW'(cap_q);
		rd_n     = (XW'(cnt_q) < XW'(fill_q)) ? XW'(cnt_q) : XW'(fill_q);
		pk_empty = (XW'(off_q) >= XW'(fill_q)) || (cnt_q == 7'd0);
		pk_avail = XW'(fill_q) - XW'(off_q);
		pk_n     = (XW'(cnt_q) < pk_avail) ? XW'(cnt_q) : pk_avail;
		// Both terms are below the capacity, so one subtract wraps the sum.
		pk_sum   = XW'(rd_idx_q) + XW'(off_q);
		pk_ptr   = (pk_sum >= XW'(cap_q)) ? AW'(pk_sum - XW'(cap_q)) : AW'(pk_sum);
		ptr_inc  = step_idx(ptr_q, cap_q);
		fd_hit   = (rdata_q == data_q);
		fd_end   = ((fi_q + 1'b1) == fill_q);
	end

	// Result beat that the current state wants to hand over.
	always_comb begin
		emit_req    = 1'b0;
		beat_status = ST_OK;
		beat_byte   = 8'd0;
		beat_pos    = 10'd0;
		beat_fill   = 11'(fill_q);
		beat_last   = 1'b1;
		unique case (state_q)
			S_DECIDE: begin
				unique case (op_q)
					OP_WRITE: begin
						emit_req = 1'b1;
						if (full) begin
							beat_status = ST_FULL;
						end else begin
							beat_fill = 11'(fill_q + 1'b1);
						end
					end
					OP_READ: begin
						emit_req    = (rd_n == '0);
						beat_status = ST_EMPTY;
					end
					OP_PEEK: begin
						emit_req    = pk_empty;
						beat_status = ST_EMPTY;
					end
					OP_FIND: begin
						emit_req    = (fill_q == '0);
						beat_status = ST_NOTFOUND;
					end
					OP_CLEAR: begin
						emit_req  = 1'b1;
						beat_fill = 11'd0;
					end
					default: begin
						emit_req = 1'b1;
					end
				endcase
			end
			S_RD_DATA: begin
				emit_req  = 1'b1;
				beat_byte = rdata_q;
				beat_last = (left_q == BW'(1));
				if (op_q == OP_READ) begin
					beat_fill = 11'(fill_q - 1'b1);
				end
			end
			S_FD_CMP: begin
				emit_req = fd_hit || fd_end;
				if (fd_hit) begin
					beat_pos = 10'(fi_q);
				end else begin
					beat_status = ST_NOTFOUND;
				end
			end
			default: begin
				emit_req = 1'b0;
			end
		endcase
	end

	assign mem_we = (state_q == S_DECIDE) && (op_q == OP_WRITE) && out_free && !full;
	assign mem_re = (state_q == S_RD_ADDR) || (state_q == S_FD_ADDR);

	// Byte store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			byte_store_q[wr_idx_q] <= data_q;
		end
		if (mem_re) begin
			rdata_q <= byte_store_q[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_WRITE;
			data_q       <= 8'd0;
			cnt_q        <= 7'd0;
			off_q        <= 10'd0;
			cap_q        <= clamp_cap(CAPACITY_RESET);
			wr_idx_q     <= '0;
			rd_idx_q     <= '0;
			fill_q       <= '0;
			ptr_q        <= '0;
			left_q       <= '0;
			fi_q         <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= ST_OK;
			byte_out_q   <= 8'd0;
			position_q   <= 10'd0;
			fill_level_q <= 11'd0;
			last_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q    <= clamp_cap(capacity);
				wr_idx_q <= '0;
				rd_idx_q <= '0;
				fill_q   <= '0;
			end

			if (emit_req && out_free) begin
				out_valid_q  <= 1'b1;
				status_q     <= beat_status;
				byte_out_q   <= beat_byte;
				position_q   <= beat_pos;
				fill_level_q <= beat_fill;
				last_q       <= beat_last;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= operation;
						data_q  <= data;
						cnt_q   <= (count > 7'(MAX_BURST)) ? 7'(MAX_BURST) : count;
						off_q   <= offset;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!emit_req) begin
						// Multi-cycle work: set up the walk over the store.
						unique case (op_q)
							OP_READ: begin
								ptr_q   <= rd_idx_q;
								left_q  <= BW'(rd_n);
								state_q <= S_RD_ADDR;
							end
							OP_PEEK: begin
								ptr_q   <= pk_ptr;
								left_q  <= BW'(pk_n);
								state_q <= S_RD_ADDR;
							end
							OP_FIND: begin
								ptr_q   <= rd_idx_q;
								fi_q    <= '0;
								state_q <= S_FD_ADDR;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end else if (out_free) begin
						state_q <= S_IDLE;
						if (op_q == OP_WRITE && !full) begin
							wr_idx_q <= step_idx(wr_idx_q, cap_q);
							fill_q   <= fill_q + 1'b1;
						end
						if (op_q == OP_CLEAR) begin
							wr_idx_q <= '0;
							rd_idx_q <= '0;
							fill_q   <= '0;
						end
					end
				end
				S_RD_ADDR: begin
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					if (out_free) begin
						ptr_q  <= ptr_inc;
						left_q <= BW'(left_q - 1'b1);
						if (op_q == OP_READ) begin
							rd_idx_q <= ptr_inc;
							fill_q   <= fill_q - 1'b1;
						end
						state_q <= (left_q == BW'(1)) ? S_IDLE : S_RD_ADDR;
					end
				end
				S_FD_ADDR: begin
					state_q <= S_FD_CMP;
				end
				S_FD_CMP: begin
					if (emit_req) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						ptr_q   <= ptr_inc;
						fi_q    <= fi_q + 1'b1;
						state_q <= S_FD_ADDR;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The fill never exceeds the effective capacity.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(fill_q) <= XW'(cap_q))
		else $error("fill count exceeds capacity");

	// Both indexes stay inside the active slot range.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(XW'(wr_idx_q) < XW'(cap_q)) && (XW'(rd_idx_q) < XW'(cap_q)))
		else $error("ring index outside capacity");

	// The RAM is never written and read in the same cycle.
	a_mem_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("RAM write and read overlap");

	// A burst byte is only fetched while bytes remain to be returned.
	a_burst_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD_ADDR || state_q == S_RD_DATA) |-> (left_q != '0))
		else $error("burst walk with no bytes left");

	// A search only compares positions that hold stored bytes.
	a_find_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FD_CMP) |-> (fi_q < fill_q))
		else $error("search past the stored bytes");

endmodule
`default_nettype wire
